// ===== rtl/nms_pkg.sv =====
// Shared types and constants for the nearest measurement search block.
// Used by nms_dist_unit and nearest_measurement_search; no dependencies.
package nms_pkg;

    localparam int ELEV_W  = 16;
    localparam int AZIM_W  = 18;
    localparam int DIST_W  = 16;
    localparam int SUM_W   = 19;
    localparam int DELTA_W = 18;
    localparam int SLOT_W  = 10;
    localparam int CNT_REG_W = 11;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [DELTA_W-1:0] DELTA_LIMIT = 18'd256000;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic signed [ELEV_W-1:0] elev;
        logic signed [AZIM_W-1:0] azim;
        logic        [DIST_W-1:0] distance;
    } t_pos;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/nms_dist_unit.sv =====
// Two-stage L1 distance unit: absolute coordinate differences, then their sum.
// Depends on nms_pkg for the position type and widths.
module nms_dist_unit #(
    parameter int IDX_W = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [IDX_W-1:0]           i_idx,
    input  nms_pkg::t_pos              i_entry,
    input  nms_pkg::t_pos              i_query,
    output logic                       o_vld,
    output logic [IDX_W-1:0]           o_idx,
    output logic [nms_pkg::SUM_W-1:0]  o_sum,
    output logic                       o_busy
);
    import nms_pkg::*;

    logic signed [ELEV_W:0] de;
    logic signed [AZIM_W:0] da;
    logic signed [DIST_W:0] dd;
    logic [ELEV_W-1:0] ae;
    logic [AZIM_W-1:0] aa;
    logic [DIST_W-1:0] ad;

    logic              r_s1_vld;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [ELEV_W-1:0] r_ae;
    logic [AZIM_W-1:0] r_aa;
    logic [DIST_W-1:0] r_ad;

    logic              r_s2_vld;
    logic [IDX_W-1:0]  r_s2_idx;
    logic [SUM_W-1:0]  r_sum;

    always_comb begin
        de = {i_entry.elev[ELEV_W-1], i_entry.elev} - {i_query.elev[ELEV_W-1], i_query.elev};
        da = {i_entry.azim[AZIM_W-1], i_entry.azim} - {i_query.azim[AZIM_W-1], i_query.azim};
        dd = $signed({1'b0, i_entry.distance}) - $signed({1'b0, i_query.distance});
        ae = de[ELEV_W] ? ELEV_W'(-de) : de[ELEV_W-1:0];
        aa = da[AZIM_W] ? AZIM_W'(-da) : da[AZIM_W-1:0];
        ad = dd[DIST_W] ? DIST_W'(-dd) : dd[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_idx;
        r_ae     <= ae;
        r_aa     <= aa;
        r_ad     <= ad;
        r_s2_idx <= r_s1_idx;
        r_sum    <= SUM_W'(r_ae) + SUM_W'(r_aa) + SUM_W'(r_ad);
    end

    assign o_vld  = r_s2_vld;
    assign o_idx  = r_s2_idx;
    assign o_sum  = r_sum;
    assign o_busy = r_s1_vld | r_s2_vld;

endmodule

// ===== rtl/nearest_measurement_search.sv =====
// Top level of the nearest measurement search: position table, scan sequencer,
// best-entry tracking and APB register. Depends on nms_pkg and nms_dist_unit.
//
// A load beat writes one table slot; slots at or above MAX_ENTRIES are
// dropped. A query beat scans entries 0 .. entry_count-1 (saturated to
// MAX_ENTRIES) through the single table read port, one entry per cycle.
// Its result beat is held until it is taken. The input is stalled from
// query acceptance until the result beat leaves.
// The table has no reset; every slot a query scans must have been loaded first.
module nearest_measurement_search #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nms_pkg::APB_AW-1:0]         paddr,
    input  logic [nms_pkg::APB_DW-1:0]         pwdata,
    output logic [nms_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_kind,
    input  logic [nms_pkg::SLOT_W-1:0]         i_entry_index,
    input  logic signed [nms_pkg::ELEV_W-1:0]  i_elevation,
    input  logic signed [nms_pkg::AZIM_W-1:0]  i_azimuth,
    input  logic [nms_pkg::DIST_W-1:0]         i_distance,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [nms_pkg::SLOT_W-1:0]         o_best_index,
    output logic [nms_pkg::DELTA_W-1:0]        o_best_delta,
    output logic                               o_found
);
    import nms_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int WX = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int XW = (CW > CNT_REG_W) ? CW + 1 : CNT_REG_W + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    t_state r_state, n_state;

    logic [CNT_REG_W-1:0] r_entry_count;
    t_pos                 r_mem [MAX_ENTRIES];
    t_pos                 r_qry;
    t_pos                 r_rd_data;
    logic                 r_rd_vld;
    logic [CW-1:0]        r_rd_idx;
    logic [CW-1:0]        r_addr;
    logic [CW-1:0]        r_last;
    logic [CW-1:0]        r_best_idx;
    logic [DELTA_W-1:0]   r_best_d;
    logic                 r_found;

    logic                 cfg_wr;
    logic                 in_acc;
    logic                 ld_wr;
    logic                 qry_acc;
    logic                 rd_en;
    logic [WX-1:0]        wr_ext;
    logic [AW-1:0]        wr_addr;
    logic [CW-1:0]        cnt_sat;
    logic [IW-1:0]        best_ext;
    t_pos                 in_pos;

    logic                 sum_vld;
    logic [CW-1:0]        sum_idx;
    logic [SUM_W-1:0]     sum;
    logic                 unit_busy;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_ENTRY_COUNT);
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? APB_DW'(r_entry_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= CNT_REG_W'(1);
        end else if (cfg_wr) begin
            r_entry_count <= pwdata[CNT_REG_W-1:0];
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid & ~o_stall;
    assign ld_wr   = in_acc & (i_kind == KIND_LOAD)
                   & (17'(i_entry_index) < 17'(MAX_ENTRIES));
    assign qry_acc = in_acc & (i_kind == KIND_QUERY);
    assign rd_en   = (r_state == ST_SCAN);

    assign wr_ext  = WX'(i_entry_index);
    assign wr_addr = wr_ext[AW-1:0];
    assign cnt_sat = (XW'(r_entry_count) > XW'(MAX_ENTRIES)) ? MAX_CNT : CW'(r_entry_count);

    always_comb begin
        in_pos.elev     = i_elevation;
        in_pos.azim     = i_azimuth;
        in_pos.distance = i_distance;
    end

    always_ff @(posedge i_clk) begin
        if (ld_wr) begin
            r_mem[wr_addr] <= in_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
        r_rd_idx <= r_addr;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (qry_acc) begin
                    n_state = (cnt_sat == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !unit_busy && !sum_vld) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_acc) begin
            r_qry      <= in_pos;
            r_addr     <= '0;
            r_last     <= cnt_sat - CW'(1);
            r_best_idx <= '0;
            r_best_d   <= DELTA_LIMIT;
            r_found    <= 1'b0;
        end else begin
            if (rd_en) begin
                r_addr <= r_addr + CW'(1);
            end
            if (sum_vld && (sum < SUM_W'(r_best_d))) begin
                r_best_idx <= sum_idx;
                r_best_d   <= sum[DELTA_W-1:0];
                r_found    <= 1'b1;
            end
        end
    end

    nms_dist_unit #(
        .IDX_W (CW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_idx   (r_rd_idx),
        .i_entry (r_rd_data),
        .i_query (r_qry),
        .o_vld   (sum_vld),
        .o_idx   (sum_idx),
        .o_sum   (sum),
        .o_busy  (unit_busy)
    );

    assign best_ext     = IW'(r_best_idx);
    assign o_valid      = (r_state == ST_OUT);
    assign o_best_index = best_ext[SLOT_W-1:0];
    assign o_best_delta = r_best_d;
    assign o_found      = r_found;

endmodule

// ===== tb/nearest_measurement_search_test.sv =====
// Self-checking testbench for nearest_measurement_search: table loads, L1 nearest-entry
// queries and entry_count writes over APB, checked against an in-bench search predictor.
// Depends on nms_pkg and the nearest_measurement_search RTL only.
module nearest_measurement_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nms_pkg::*;

    localparam int MAX_SLOTS = 1024;
    localparam int E_LIM = 23040;
    localparam int A_LIM = 92160;
    localparam int D_LIM = 65535;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        t_pos              pos;
    } t_beat;

    typedef struct packed {
        logic [SLOT_W-1:0]  idx;
        logic [DELTA_W-1:0] delta;
        logic               found;
    } t_hit;

    typedef struct packed {
        logic                 set_cfg;
        logic [CNT_REG_W-1:0] cfg;
        t_beat                beat;
        logic                 typed;
        t_hit                 want;
    } t_step;

    localparam t_hit MISS = '{'0, DELTA_LIMIT, 1'b0};

    localparam t_step DIRECTED [17] = '{
        '{1'b0, 11'd0, '{KIND_LOAD, 10'd0, '{'0, '0, '0}}, 1'b0, MISS},
        '{1'b0, 11'd0, '{KIND_QUERY, 10'd0, '{'0, '0, '0}},
          1'b1, '{10'd0, 18'd0, 1'b1}},
        '{1'b0, 11'd0, '{KIND_QUERY, 10'd1023, '{16'sd23040, 18'sd92160, 16'd65535}},
          1'b1, '{10'd0, 18'd180735, 1'b1}},
        '{1'b0, 11'd0, '{KIND_LOAD, 10'd0, '{-16'sd23040, -18'sd92160, 16'd0}},
          1'b0, MISS},
        '{1'b0, 11'd0, '{KIND_QUERY, 10'd0, '{16'sd23040, 18'sd92160, 16'd65535}},
          1'b1, MISS},
        '{1'b0, 11'd0, '{KIND_LOAD, 10'd0, '{16'sd0, -18'sd92160, 16'd0}}, 1'b0, MISS},
        '{1'b0, 11'd0, '{KIND_QUERY, 10'd0, '{16'sd23040, 18'sd92160, 16'd48640}},
          1'b1, MISS},
        '{1'b0, 11'd0, '{KIND_QUERY, 10'd0, '{16'sd23040, 18'sd92160, 16'd48639}},
          1'b1, '{10'd0, 18'd255999, 1'b1}},
        '{1'b0, 11'd0, '{KIND_LOAD, 10'd1, '{16'sd100, 18'sd200, 16'd300}}, 1'b0, MISS},
        '{1'b0, 11'd0, '{KIND_LOAD, 10'd2, '{-16'sd100, -18'sd200, 16'd300}},
          1'b0, MISS},
        '{1'b0, 11'd0, '{KIND_LOAD, 10'd3, '{16'sd500, 18'sd0, 16'd0}}, 1'b0, MISS},
        '{1'b1, 11'd4, '{KIND_QUERY, 10'd0, '{16'sd0, 18'sd0, 16'd300}},
          1'b1, '{10'd1, 18'd300, 1'b1}},
        '{1'b1, 11'd0, '{KIND_QUERY, 10'd0, '{16'sd0, 18'sd0, 16'd300}}, 1'b1, MISS},
        '{1'b1, 11'd3, '{KIND_QUERY, 10'd0, '{-16'sd100, -18'sd200, 16'd300}},
          1'b0, MISS},
        '{1'b0, 11'd0, '{KIND_LOAD, 10'd1023, '{-16'sd23040, 18'sd92160, 16'd65535}},
          1'b0, MISS},
        '{1'b0, 11'd0, '{KIND_LOAD, 10'd512, '{16'sd23040, -18'sd92160, 16'd0}},
          1'b0, MISS},
        '{1'b1, 11'd1, '{KIND_QUERY, 10'd0, '{-16'sd23040, -18'sd92160, 16'd0}},
          1'b0, MISS}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_kind = KIND_LOAD;
    logic [SLOT_W-1:0] i_entry_index = '0;
    logic signed [ELEV_W-1:0] i_elevation = '0;
    logic signed [AZIM_W-1:0] i_azimuth = '0;
    logic [DIST_W-1:0] i_distance = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [SLOT_W-1:0] o_best_index;
    logic [DELTA_W-1:0] o_best_delta;
    logic o_found;

    t_pos pos_table [MAX_SLOTS];
    bit loaded [MAX_SLOTS];
    logic [CNT_REG_W-1:0] scan_count = 11'd1;
    t_hit awaited_hits [$];
    bit calm = 1'b0;
    int mismatches = 0;
    int n_loads = 0;
    int n_queries = 0;
    int n_checked = 0;

    nearest_measurement_search #(
        .MAX_ENTRIES(MAX_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_kind(i_kind),
        .i_entry_index(i_entry_index),
        .i_elevation(i_elevation),
        .i_azimuth(i_azimuth),
        .i_distance(i_distance),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_best_index(o_best_index),
        .o_best_delta(o_best_delta),
        .o_found(o_found)
    );

    always #5 i_clk = ~i_clk;

    function automatic int scan_limit();
        return (scan_count > CNT_REG_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(scan_count);
    endfunction

    function automatic int gap(input int a, input int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic t_hit nearest_entry(input t_pos q);
        t_hit h;
        int sum;
        h = MISS;
        for (int k = 0; k < scan_limit(); k++) begin
            sum = gap(pos_table[k].elev, q.elev) + gap(pos_table[k].azim, q.azim)
                + gap(pos_table[k].distance, q.distance);
            if (sum < int'(h.delta)) begin
                h.idx = SLOT_W'(k);
                h.delta = DELTA_W'(sum);
                h.found = 1'b1;
            end
        end
        return h;
    endfunction

    function automatic t_pos any_pos();
        t_pos p;
        p.elev = ELEV_W'(int'($urandom_range(0, 2 * E_LIM)) - E_LIM);
        p.azim = AZIM_W'(int'($urandom_range(0, 2 * A_LIM)) - A_LIM);
        p.distance = DIST_W'($urandom_range(0, D_LIM));
        return p;
    endfunction

    function automatic int nudge(input int v, input int lo, input int hi, input int amount);
        int r;
        r = v + int'($urandom_range(0, 2 * amount)) - amount;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    function automatic t_beat fresh_load(input logic [SLOT_W-1:0] slot);
        t_beat b;
        int j;
        b.kind = KIND_LOAD;
        b.slot = slot;
        b.pos = any_pos();
        if (scan_limit() > 0 && $urandom_range(0, 99) < 15) begin
            j = $urandom_range(0, scan_limit() - 1);
            if (loaded[j]) b.pos = pos_table[j];
        end
        return b;
    endfunction

    function automatic t_beat pick_query();
        t_beat b;
        int j;
        int amount;
        b.kind = KIND_QUERY;
        b.slot = SLOT_W'($urandom);
        b.pos = any_pos();
        if (scan_limit() > 0 && $urandom_range(0, 99) < 60) begin
            j = $urandom_range(0, scan_limit() - 1);
            amount = ($urandom_range(0, 3) == 0) ? 40000 : 300;
            b.pos.elev = ELEV_W'(nudge(pos_table[j].elev, -E_LIM, E_LIM, amount));
            b.pos.azim = AZIM_W'(nudge(pos_table[j].azim, -A_LIM, A_LIM, amount));
            b.pos.distance = DIST_W'(nudge(pos_table[j].distance, 0, D_LIM, amount));
        end
        return b;
    endfunction

    task automatic issue(input t_beat b, input logic typed, input t_hit want);
        while (!calm && $urandom_range(0, 99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= b.kind;
        i_entry_index <= b.slot;
        i_elevation <= b.pos.elev;
        i_azimuth <= b.pos.azim;
        i_distance <= b.pos.distance;
        do @(posedge i_clk); while (o_stall);
        if (b.kind == KIND_LOAD) begin
            pos_table[b.slot] = b.pos;
            loaded[b.slot] = 1'b1;
            n_loads++;
        end else begin
            awaited_hits.push_back(typed ? want : nearest_entry(b.pos));
            n_queries++;
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (awaited_hits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_REG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ENTRY_COUNT, 2'b00};
        pwdata <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        scan_count = value;
    endtask

    task automatic flag(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : sink
        t_hit want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t ns: result beat with no query waiting", $time);
                end else begin
                    want = awaited_hits.pop_front();
                    n_checked++;
                    if (o_best_index !== want.idx) flag("best_index", want.idx, o_best_index);
                    if (o_best_delta !== want.delta) flag("best_delta", want.delta, o_best_delta);
                    if (o_found !== want.found) flag("found", want.found, o_found);
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 8);
        end
    end

    initial begin : stimulus
        int span;
        int slot;
        foreach (pos_table[k]) pos_table[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].set_cfg) begin
                settle();
                write_count(DIRECTED[r].cfg);
            end
            issue(DIRECTED[r].beat, DIRECTED[r].typed, DIRECTED[r].want);
        end

        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph == 5 || ph == 6);
            if (ph == 0) span = 1;
            else if (ph == 1) span = 0;
            else if (ph % 4 == 3) span = $urandom_range(64, 160);
            else span = $urandom_range(2, 24);
            settle();
            write_count(CNT_REG_W'(span));
            for (int k = 0; k < span; k++)
                if (!loaded[k]) issue(fresh_load(SLOT_W'(k)), 1'b0, MISS);
            repeat ($urandom_range(32, 44)) begin
                if ($urandom_range(0, 99) < 35) begin
                    if ($urandom_range(0, 3) == 0) slot = $urandom_range(0, MAX_SLOTS - 1);
                    else slot = $urandom_range(0, (span + 7 > MAX_SLOTS - 1) ?
                                                  MAX_SLOTS - 1 : span + 7);
                    issue(fresh_load(SLOT_W'(slot)), 1'b0, MISS);
                end else begin
                    issue(pick_query(), 1'b0, MISS);
                end
            end
        end

        calm = 1'b0;
        settle();
        $display("%0d loads and %0d queries sent, %0d results checked", n_loads, n_queries,
                 n_checked);
        $display("entry_count swept over 0, 1 and small to mid sizes, with stalls both ways");
        if (mismatches == 0) begin
            $display("nearest_measurement_search: match");
        end else begin
            $display("nearest_measurement_search: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("nearest_measurement_search: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nms_pkg.sv
rtl/nms_dist_unit.sv
rtl/nearest_measurement_search.sv
tb/nearest_measurement_search_test.sv
